### rtl/assert_macros.svh
// assertion macros shared by the reservation table rtl
// no dependencies; checks compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition that holds at every clock edge out of reset
`define ASSERT_CLK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// condition that implies another at the next clock edge
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, cond, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/srt_pkg.sv
// types, sizes and status codes for the sorted interval reservation table
// no dependencies; imported by srt_cell and the top level
package srt_pkg;

    localparam int ENTRIES   = 64;
    localparam int SEAT_BITS = 16;
    localparam int OWNER_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // request codes
    localparam logic ACT_RESERVE = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd4;

    typedef logic [SEAT_BITS-1:0] seat_t;

    // input word
    typedef struct packed {
        logic                action;
        logic [15:0]         first_seat;
        logic [15:0]         last_seat;
        logic [OWNER_W-1:0]  owner_id;
        logic [15:0]         query_seat;
    } req_t;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OWNER_W-1:0]  holder;
    } rsp_t;

    // one stored range
    typedef struct packed {
        seat_t               first;
        seat_t               last;
        logic [OWNER_W-1:0]  owner;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        seat_t               seat;      // position searched for
        seat_t               bound;     // a hit needs range start at or below this
        logic                insert;    // write the new range this cycle
        entry_t              new_entry;
    } cell_ctl_t;

    // handed from each cell to the next one up
    typedef struct packed {
        logic                reach;     // some cell at or below ends at or past seat
        logic                after;     // this cell sits at or past the insert point
    } link_t;

endpackage

### rtl/srt_cell.sv
// one slot of the sorted range chain: holds a range, compares, shifts up on insert
// depends on srt_pkg
module srt_cell
    import srt_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  link_t     link_in,
    input  entry_t    entry_in,
    output link_t     link_out,
    output entry_t    entry,
    output logic      hit,
    output logic [OWNER_W-1:0] holder
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   reach_here;
    logic   first_reach;

    // this slot ends at or past the searched seat
    assign reach_here  = occupied && (entry_reg.last >= ctl.seat);
    assign first_reach = reach_here && !link_in.reach;

    assign link_out.reach = link_in.reach || reach_here;
    assign link_out.after = reach_here || !occupied;

    // the first reaching slot holds the seat if it starts early enough
    assign hit    = first_reach && (entry_reg.first <= ctl.bound);
    assign holder = hit ? entry_reg.owner : '0;
    assign entry  = entry_reg;

    // insert point takes the new range, slots above take their neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert)
        begin
            if (link_in.after)
                entry_next = entry_in;
            else if (link_out.after)
                entry_next = ctl.new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/sorted_interval_reservation_table.sv
// top level of the sorted interval reservation table: control and result
// depends on srt_pkg, srt_cell and assert_macros.svh
//
// Usage: present a request word on cmd with start high; it is taken at the
// rising edge where start is high and busy is low. Action reserve stores the
// range first_seat..last_seat for owner_id if first_seat is not above last_seat,
// it overlaps nothing and the table has room; action query looks up query_seat.
// The accepting edge sets busy; done, registered from busy, then pulses for one
// cycle, with result.status and result.holder valid in that cycle.
// A request is not taken while busy is high; busy is high for the single
// cycle in which the chain of 64 cells compares every stored range at once
// and, on a successful reserve, shifts the ranges above the insert point up
// one cell. The next request can be taken in the same cycle done is high.
// Reset clears the fill count, so the table starts empty; cell contents are
// not cleared and are ignored above the fill count.
// The receiver cannot stall: done marks each result for exactly one cycle.
`include "assert_macros.svh"

module sorted_interval_reservation_table
    import srt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t cmd,
    output logic busy,
    output logic done,
    output rsp_t result
);

    req_t             req_reg;
    logic             busy_reg;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    cell_ctl_t          ctl;
    link_t              link  [ENTRIES+1];
    entry_t             entry [ENTRIES];
    logic [ENTRIES-1:0] hit;
    logic [OWNER_W-1:0] holder [ENTRIES];

    logic               accept;
    logic               is_query;
    logic               full;
    logic               reversed;
    logic               any_hit;
    logic [OWNER_W-1:0] holder_any;
    logic               do_insert;

    assign accept   = start && !busy_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign result   = rsp_reg;

    // request decode
    assign is_query = (req_reg.action == ACT_QUERY);
    assign full     = (count_reg == CNT_W'(ENTRIES));
    assign reversed = (seat_t'(req_reg.first_seat) > seat_t'(req_reg.last_seat));

    // broadcast to the chain
    always_comb
    begin
        ctl.seat  = is_query ? seat_t'(req_reg.query_seat) : seat_t'(req_reg.first_seat);
        ctl.bound = is_query ? seat_t'(req_reg.query_seat) : seat_t'(req_reg.last_seat);
        ctl.new_entry.first = seat_t'(req_reg.first_seat);
        ctl.new_entry.last  = seat_t'(req_reg.last_seat);
        ctl.new_entry.owner = req_reg.owner_id;
        ctl.insert = do_insert;
    end

    assign link[0].reach = 1'b0;
    assign link[0].after = 1'b0;

    // chain of cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        entry_t below;
        if (i == 0)
        begin : g_bottom
            assign below = ctl.new_entry;
        end
        else
        begin : g_upper
            assign below = entry[i-1];
        end

        srt_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .occupied (count_reg > CNT_W'(i)),
            .link_in  (link[i]),
            .entry_in (below),
            .link_out (link[i+1]),
            .entry    (entry[i]),
            .hit      (hit[i]),
            .holder   (holder[i])
        );
    end

    // at most one cell hits, so an or of the owners picks it
    always_comb
    begin
        holder_any = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            holder_any = holder_any | holder[i];
        end
    end

    assign any_hit   = |hit;
    assign do_insert = busy_reg && !is_query && !full && !reversed && !any_hit;

    // result and fill count
    always_comb
    begin
        rsp_next.holder = '0;
        count_next      = count_reg;
        if (is_query)
        begin
            rsp_next.status = any_hit ? ST_TAKEN : ST_FREE;
            rsp_next.holder = any_hit ? holder_any : '0;
        end
        else if (full)
        begin
            rsp_next.status = ST_FULL;
        end
        else if (reversed || any_hit)
        begin
            rsp_next.status = ST_OVERLAP;
        end
        else
        begin
            rsp_next.status = ST_RESERVED;
        end
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= cmd;
        end
        if (busy_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // checks
    `ASSERT_NEXT(a_done_follows_busy, busy_reg, done_reg, "result strobe missing after busy cycle")
    `ASSERT_CLK(a_count_bounded, count_reg <= CNT_W'(ENTRIES), "fill count past table size")
    `ASSERT_CLK(a_done_not_busy, !(done_reg && busy_reg), "result strobe while busy")
    `ASSERT_CLK(a_count_moves_on_reserve, (count_reg != $past(count_reg)) |-> (done_reg && rsp_reg.status == ST_RESERVED), "fill count changed without a reservation")

endmodule
